[rtl/mbcc_pkg.sv]
// Package with shared constants, types and helper functions of the causal convolution.
`default_nettype none

package mbcc_pkg;

  // Array sizes.
  localparam int CHANNELS     = 1024;
  localparam int MAX_BRANCHES = 4;
  localparam int TAP_SLOTS    = 8;
  localparam int KS_REGS      = 4;

  // Field and index widths.
  localparam int CH_W    = 10;
  localparam int BR_W    = 2;
  localparam int TAP_W   = 3;
  localparam int BC_W    = 3;
  localparam int KS_W    = 4;
  localparam int DATA_W  = 16;
  localparam int WADDR_W = TAP_W + CH_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 4;

  // Arithmetic widths: Q3.12 times Q1.14 gives Q.26 products.
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + 6;
  localparam int FRAC_SHIFT = 14;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(8192);
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = ACC_W'(-32768);

  // Request kinds.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BRANCH_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE_3 = 3'd4;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [TAP_SLOTS-1:0]    tap_row_t;
  typedef tap_row_t [MAX_BRANCHES-1:0] hist_row_t;
  typedef word_t [MAX_BRANCHES-1:0] wgt_row_t;

  typedef struct packed {
    logic [BC_W-1:0]             branch_count;
    logic [KS_REGS-1:0][KS_W-1:0] kernel_size;
  } cfg_t;

  typedef struct packed {
    logic             clear;
    logic             mul_en;
    logic [TAP_W-1:0] tap;
    logic             sum_en;
  } mac_ctl_t;

  // Active branch count, limited to the branches that exist.
  function automatic logic [BC_W-1:0] eff_branches(input logic [BC_W-1:0] bc);
    eff_branches = (bc > BC_W'(MAX_BRANCHES)) ? BC_W'(MAX_BRANCHES) : bc;
  endfunction

  // Tap count of a branch: zero acts as one, large values stop at the maximum.
  function automatic logic [KS_W-1:0] eff_kernel(input logic [KS_W-1:0] ks);
    if (ks == '0) begin
      eff_kernel = KS_W'(1);
    end else if (ks > KS_W'(TAP_SLOTS)) begin
      eff_kernel = KS_W'(TAP_SLOTS);
    end else begin
      eff_kernel = ks;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/mbcc_hist.sv]
// History memory with its clearing sweep and the read-shift-write of one channel row.
`default_nettype none

module mbcc_hist (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      rd_en,
  input  wire [mbcc_pkg::CH_W-1:0] rd_addr,
  input  wire                      shift_en,
  input  wire [mbcc_pkg::CH_W-1:0] wr_addr,
  input  mbcc_pkg::word_t          sample,
  input  mbcc_pkg::cfg_t           cfg,
  output logic                     clr_busy,
  output mbcc_pkg::hist_row_t      hrow
);

  mbcc_pkg::hist_row_t hist_mem [mbcc_pkg::CHANNELS];
  mbcc_pkg::hist_row_t rd_row;
  mbcc_pkg::hist_row_t shifted;
  logic [mbcc_pkg::CH_W-1:0] clr_addr;

  // Clearing sweep after reset, one channel row per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + mbcc_pkg::CH_W'(1);
      if (clr_addr == mbcc_pkg::CH_W'(mbcc_pkg::CHANNELS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Memory port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      hist_mem[clr_addr] <= '0;
    end else if (shift_en) begin
      hist_mem[wr_addr] <= shifted;
    end
    if (rd_en) begin
      rd_row <= hist_mem[rd_addr];
    end
  end

  // Each active branch moves one place toward tap 0 and takes the sample as newest tap.
  always_comb begin
    logic [mbcc_pkg::BC_W-1:0] nb;
    logic [mbcc_pkg::KS_W-1:0] ks;
    shifted = rd_row;
    nb = mbcc_pkg::eff_branches(cfg.branch_count);
    ks = '0;
    for (int b = 0; b < mbcc_pkg::MAX_BRANCHES; b++) begin
      if (mbcc_pkg::BC_W'(b) < nb) begin
        ks = mbcc_pkg::eff_kernel(cfg.kernel_size[b]);
        for (int k = 0; k < mbcc_pkg::TAP_SLOTS - 1; k++) begin
          if (mbcc_pkg::KS_W'(k) + mbcc_pkg::KS_W'(1) < ks) begin
            shifted[b][k] = rd_row[b][k+1];
          end
        end
        for (int k = 0; k < mbcc_pkg::TAP_SLOTS; k++) begin
          if (mbcc_pkg::KS_W'(k) + mbcc_pkg::KS_W'(1) == ks) begin
            shifted[b][k] = sample;
          end
        end
      end
    end
  end

  // Updated row held for the multiply-accumulate pass.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      hrow <= shifted;
    end
  end

endmodule

`default_nettype wire

[rtl/mbcc_wgt.sv]
// Weight memory: one row per tap and channel, one lane per branch.
`default_nettype none

module mbcc_wgt (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [mbcc_pkg::WADDR_W-1:0] wr_addr,
  input  wire [mbcc_pkg::BR_W-1:0]    wr_lane,
  input  mbcc_pkg::word_t             wr_data,
  input  wire                         rd_en,
  input  wire [mbcc_pkg::WADDR_W-1:0] rd_addr,
  output mbcc_pkg::wgt_row_t          rd_row
);

  mbcc_pkg::wgt_row_t wgt_mem [mbcc_pkg::TAP_SLOTS * mbcc_pkg::CHANNELS];

  // Lane write for weight loads, full-row registered read for the taps.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wgt_mem[wr_addr][wr_lane] <= wr_data;
    end
    if (rd_en) begin
      rd_row <= wgt_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/mbcc_mac.sv]
// Per-branch multiply-accumulate lanes, branch sum, rounding and saturation.
`default_nettype none

module mbcc_mac (
  input  wire                 clk,
  input  wire                 rst,
  input  mbcc_pkg::mac_ctl_t  ctl,
  input  mbcc_pkg::cfg_t      cfg,
  input  mbcc_pkg::hist_row_t hrow,
  input  mbcc_pkg::wgt_row_t  wrow,
  output mbcc_pkg::word_t     conv_out,
  output logic                saturated
);

  logic signed [mbcc_pkg::PROD_W-1:0] prod [mbcc_pkg::MAX_BRANCHES];
  logic signed [mbcc_pkg::ACC_W-1:0]  acc  [mbcc_pkg::MAX_BRANCHES];
  logic signed [mbcc_pkg::ACC_W-1:0]  total;
  logic signed [mbcc_pkg::ACC_W-1:0]  total_next;
  logic signed [mbcc_pkg::ACC_W-1:0]  quot;
  logic                               prod_vld;
  logic [mbcc_pkg::BC_W-1:0]          nb;

  assign nb = mbcc_pkg::eff_branches(cfg.branch_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.mul_en;
    end
  end

  // One product per branch per cycle while mul_en is high; inactive branches and taps past the kernel length give zero.
  always_ff @(posedge clk) begin
    for (int b = 0; b < mbcc_pkg::MAX_BRANCHES; b++) begin
      if (ctl.mul_en) begin
        if (mbcc_pkg::BC_W'(b) < nb &&
            mbcc_pkg::KS_W'(ctl.tap) < mbcc_pkg::eff_kernel(cfg.kernel_size[b])) begin
          prod[b] <= $signed(hrow[b][ctl.tap]) * $signed(wrow[b]);
        end else begin
          prod[b] <= '0;
        end
      end
    end
  end

  // Accumulators start clean for every sample.
  always_ff @(posedge clk) begin
    for (int b = 0; b < mbcc_pkg::MAX_BRANCHES; b++) begin
      if (ctl.clear) begin
        acc[b] <= '0;
      end else if (prod_vld) begin
        acc[b] <= acc[b] + mbcc_pkg::ACC_W'(prod[b]);
      end
    end
  end

  // Sum over branches with the half-step rounding offset.
  always_comb begin
    total_next = mbcc_pkg::ROUND_HALF;
    for (int b = 0; b < mbcc_pkg::MAX_BRANCHES; b++) begin
      total_next = total_next + acc[b];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      total <= total_next;
    end
  end

  // Floor to Q3.12 and clip to the 16-bit range.
  always_comb begin
    quot = total >>> mbcc_pkg::FRAC_SHIFT;
    if (quot > mbcc_pkg::SAT_MAX) begin
      conv_out  = mbcc_pkg::DATA_W'(mbcc_pkg::SAT_MAX);
      saturated = 1'b1;
    end else if (quot < mbcc_pkg::SAT_MIN) begin
      conv_out  = mbcc_pkg::DATA_W'(mbcc_pkg::SAT_MIN);
      saturated = 1'b1;
    end else begin
      conv_out  = quot[mbcc_pkg::DATA_W-1:0];
      saturated = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/multi_branch_causal_conv.sv]
// Top level of the multi-branch depthwise causal convolution.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+---------------------------------------------
//   input   | in_valid / in_stall     | func, channel, branch_sel, tap_sel, data_value
//   output  | out_valid / out_stall   | out_channel, conv_out, saturated
//   config  | cfg_wr_en               | cfg_index, cfg_data
//
// A weight load is written in the cycle it is accepted, and the block stays idle for the
// next request. A sample holds off the next request until its pass is done: one history
// row read and write-back, eight tap steps with one multiply-accumulate per branch per
// step, then sum, rounding and output. After reset the history memory is cleared one
// channel row per cycle, all 1024 rows; in_stall stays high during the sweep. The output
// register lets a new request in while a result waits; a sample finishes only once that register is free.
`default_nettype none

module multi_branch_causal_conv (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              func,
  input  wire [mbcc_pkg::CH_W-1:0]         channel,
  input  wire [mbcc_pkg::BR_W-1:0]         branch_sel,
  input  wire [mbcc_pkg::TAP_W-1:0]        tap_sel,
  input  wire signed [mbcc_pkg::DATA_W-1:0] data_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [mbcc_pkg::CH_W-1:0]        out_channel,
  output logic signed [mbcc_pkg::DATA_W-1:0] conv_out,
  output logic                             saturated,
  input  wire                              cfg_wr_en,
  input  wire [mbcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [mbcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [mbcc_pkg::CH_W:0] CH_LIMIT = (mbcc_pkg::CH_W + 1)'(mbcc_pkg::CHANNELS);

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [mbcc_pkg::TAP_W-1:0]   tap;
  logic [mbcc_pkg::CH_W-1:0]    ch;
  mbcc_pkg::word_t              val;
  mbcc_pkg::cfg_t               cfg;
  mbcc_pkg::mac_ctl_t           mac_ctl;
  mbcc_pkg::hist_row_t          hrow;
  mbcc_pkg::wgt_row_t           wrow;
  mbcc_pkg::word_t              mac_conv;
  logic                         mac_sat;
  logic                         clr_busy;
  logic                         in_acc;
  logic                         ch_ok;
  logic                         sample_acc;
  logic                         load_acc;
  logic                         out_free;
  logic                         wgt_rd_en;
  logic [mbcc_pkg::WADDR_W-1:0] wgt_rd_addr;
  logic [mbcc_pkg::TAP_W-1:0]   rd_tap;

  // Request acceptance and decode.
  assign in_stall   = (state != S_IDLE) || clr_busy;
  assign in_acc     = in_valid && !in_stall;
  assign ch_ok      = {1'b0, channel} < CH_LIMIT;
  assign sample_acc = in_acc && ch_ok && (func == mbcc_pkg::FUNC_SAMPLE);
  assign load_acc   = in_acc && ch_ok && (func == mbcc_pkg::FUNC_LOAD);
  assign out_free   = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.branch_count <= mbcc_pkg::BC_W'(1);
      for (int i = 0; i < mbcc_pkg::KS_REGS; i++) begin
        cfg.kernel_size[i] <= mbcc_pkg::KS_W'(1);
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mbcc_pkg::REG_BRANCH_COUNT:  cfg.branch_count   <= cfg_data[mbcc_pkg::BC_W-1:0];
        mbcc_pkg::REG_KERNEL_SIZE_0: cfg.kernel_size[0] <= cfg_data;
        mbcc_pkg::REG_KERNEL_SIZE_1: cfg.kernel_size[1] <= cfg_data;
        mbcc_pkg::REG_KERNEL_SIZE_2: cfg.kernel_size[2] <= cfg_data;
        mbcc_pkg::REG_KERNEL_SIZE_3: cfg.kernel_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample_acc) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: state_next = S_MAC;
      S_MAC: begin
        if (tap == mbcc_pkg::TAP_W'(mbcc_pkg::TAP_SLOTS - 1)) begin
          state_next = S_ACC;
        end
      end
      S_ACC: state_next = S_SUM;
      S_SUM: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SHIFT) begin
        tap <= '0;
      end else if (state == S_MAC) begin
        tap <= tap + mbcc_pkg::TAP_W'(1);
      end
    end
  end

  // Sample context held for the whole pass.
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      ch  <= channel;
      val <= data_value;
    end
  end

  // Weight reads run one tap ahead of the multiply step.
  assign wgt_rd_en   = (state == S_SHIFT) || (state == S_MAC);
  assign rd_tap      = (state == S_SHIFT) ? '0 : tap + mbcc_pkg::TAP_W'(1);
  assign wgt_rd_addr = {rd_tap, ch};

  assign mac_ctl.clear  = (state == S_SHIFT);
  assign mac_ctl.mul_en = (state == S_MAC);
  assign mac_ctl.tap    = tap;
  assign mac_ctl.sum_en = (state == S_SUM);

  mbcc_hist u_hist (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (sample_acc),
    .rd_addr  (channel),
    .shift_en (state == S_SHIFT),
    .wr_addr  (ch),
    .sample   (val),
    .cfg      (cfg),
    .clr_busy (clr_busy),
    .hrow     (hrow)
  );

  mbcc_wgt u_wgt (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr ({tap_sel, channel}),
    .wr_lane (branch_sel),
    .wr_data (data_value),
    .rd_en   (wgt_rd_en),
    .rd_addr (wgt_rd_addr),
    .rd_row  (wrow)
  );

  mbcc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .cfg       (cfg),
    .hrow      (hrow),
    .wrow      (wrow),
    .conv_out  (mac_conv),
    .saturated (mac_sat)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_channel <= ch;
      conv_out    <= mac_conv;
      saturated   <= mac_sat;
    end
  end

  // No request gets in while the history memory is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> in_stall)
    else $error("request accepted during history clear");

  // An accepted sample starts the row update in the next cycle.
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    sample_acc |=> state == S_SHIFT)
    else $error("accepted sample did not start a pass");

  // Leaving the output step always leaves a result in the output register.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> out_valid)
    else $error("finished sample produced no result");

  // A clipped result sits at one of the range limits.
  a_sat_limits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (conv_out == 16'sh7fff || conv_out == 16'sh8000))
    else $error("saturation flag without a limit value");

endmodule

`default_nettype wire
